// ----- hdl/epsm_pkg.sv -----
// Shared types, constants and field arithmetic for the elliptic-curve point
// scalar multiplier. Used by the interfaces, the controller and the datapath.
// No dependencies.
package epsm_pkg;

   localparam int FIELD_BITS   = 8;
   localparam int SCALAR_BITS  = 16;
   localparam int CNT_BITS     = $clog2(FIELD_BITS + 1);
   localparam int CSR_IDX_BITS = 1;

   typedef logic [FIELD_BITS-1:0]   field_type;
   typedef logic [SCALAR_BITS-1:0]  scalar_type;
   typedef logic [CNT_BITS-1:0]     cnt_type;
   typedef logic [CSR_IDX_BITS-1:0] csr_idx_type;

   localparam csr_idx_type REG_MODULUS = csr_idx_type'(0);
   localparam csr_idx_type REG_CURVE_A = csr_idx_type'(1);

   localparam field_type MODULUS_RESET = field_type'(97);
   localparam field_type CURVE_A_RESET = field_type'(2);

   typedef enum logic [4:0] {
      OP_NOP, OP_CAPTURE, OP_RED_X, OP_RED_Y, OP_RED_A, OP_LOAD_PQ,
      OP_MUL_XX, OP_NUM_DBL, OP_NUM_ADD, OP_INV, OP_MUL_NI, OP_MUL_LL,
      OP_X3, OP_SUB_X, OP_MUL_LT, OP_Y3, OP_WR_P, OP_WR_Q, OP_WR_INF,
      OP_WR_NEW, OP_SHIFT_K, OP_OUT
   } op_type;

   // sel_dbl picks the doubling of the running power instead of the
   // accumulator update.
   typedef struct packed {
      op_type op;
      logic   sel_dbl;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic p_inf;
      logic q_inf;
      logic opp;
      logic dbl;
      logic inv_ok;
      logic k_zero;
      logic k_lsb;
      logic skip;
      logic out_busy;
   } status_type;

   // Both operands are below m.
   function automatic field_type fadd(field_type u, field_type v, field_type m);
      logic [FIELD_BITS:0] s;
      s = {1'b0, u} + {1'b0, v};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
      return s[FIELD_BITS-1:0];
   endfunction

   // The wrap of the narrow subtraction gives the right value below m.
   function automatic field_type fsub(field_type u, field_type v, field_type m);
      field_type d;
      d = u - v;
      if (u < v) d = d + m;
      return d;
   endfunction

endpackage

// ----- hdl/epsm_req_if.sv -----
// Request channel of the point multiplier: valid/ready and the input point.
// Depends on epsm_pkg.
interface epsm_req_if;
   logic                   valid;
   logic                   ready;
   epsm_pkg::field_type    base_x;
   epsm_pkg::field_type    base_y;
   logic                   base_infinity;
   epsm_pkg::scalar_type   scalar;

   modport source (output valid, base_x, base_y, base_infinity, scalar, input ready);
   modport sink   (input valid, base_x, base_y, base_infinity, scalar, output ready);
endinterface

// ----- hdl/epsm_rsp_if.sv -----
// Response channel of the point multiplier: valid/ready and the product point.
// Depends on epsm_pkg.
interface epsm_rsp_if;
   logic                valid;
   logic                ready;
   epsm_pkg::field_type result_x;
   epsm_pkg::field_type result_y;
   logic                result_infinity;

   modport source (output valid, result_x, result_y, result_infinity, input ready);
   modport sink   (input valid, result_x, result_y, result_infinity, output ready);
endinterface

// ----- hdl/epsm_ctrl.sv -----
// Sequencer of the point multiplier: walks the scalar bits and steps the
// datapath through each affine point addition or doubling. Depends on epsm_pkg.
module epsm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  epsm_pkg::status_type status,
   output epsm_pkg::cmd_type    cmd
);

   typedef enum logic [23:0] {
      S_IDLE   = 24'd1 << 0,
      S_START  = 24'd1 << 1,
      S_RED_X  = 24'd1 << 2,
      S_RED_Y  = 24'd1 << 3,
      S_RED_A  = 24'd1 << 4,
      S_LOOP   = 24'd1 << 5,
      S_PQ     = 24'd1 << 6,
      S_CHECK  = 24'd1 << 7,
      S_MSQ    = 24'd1 << 8,
      S_NUMDBL = 24'd1 << 9,
      S_NUMADD = 24'd1 << 10,
      S_INV    = 24'd1 << 11,
      S_LAM    = 24'd1 << 12,
      S_LL     = 24'd1 << 13,
      S_X3     = 24'd1 << 14,
      S_SUBX   = 24'd1 << 15,
      S_MLT    = 24'd1 << 16,
      S_Y3     = 24'd1 << 17,
      S_WR_P   = 24'd1 << 18,
      S_WR_Q   = 24'd1 << 19,
      S_WR_INF = 24'd1 << 20,
      S_WR_NEW = 24'd1 << 21,
      S_SHIFT  = 24'd1 << 22,
      S_FIN    = 24'd1 << 23
   } state_type;

   state_type state_ff, state_in;
   logic      sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      sel_in      = sel_ff;
      req_ready   = 1'b0;
      cmd.op      = epsm_pkg::OP_NOP;
      cmd.sel_dbl = sel_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = epsm_pkg::OP_CAPTURE;
               state_in = S_START;
            end
         end
         S_START: state_in = status.skip ? S_FIN : S_RED_X;
         S_RED_X: begin
            cmd.op = epsm_pkg::OP_RED_X;
            if (status.done) state_in = S_RED_Y;
         end
         S_RED_Y: begin
            cmd.op = epsm_pkg::OP_RED_Y;
            if (status.done) state_in = S_RED_A;
         end
         S_RED_A: begin
            cmd.op = epsm_pkg::OP_RED_A;
            if (status.done) state_in = S_LOOP;
         end
         S_LOOP: begin
            if (status.k_zero) begin
               state_in = S_FIN;
            end else begin
               sel_in   = !status.k_lsb;
               state_in = S_PQ;
            end
         end
         S_PQ: begin
            cmd.op   = epsm_pkg::OP_LOAD_PQ;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            priority if (status.p_inf) state_in = S_WR_Q;
            else if (status.q_inf)     state_in = S_WR_P;
            else if (status.opp)       state_in = S_WR_INF;
            else if (status.dbl)       state_in = S_MSQ;
            else                       state_in = S_NUMADD;
         end
         S_MSQ: begin
            cmd.op = epsm_pkg::OP_MUL_XX;
            if (status.done) state_in = S_NUMDBL;
         end
         S_NUMDBL: begin
            cmd.op   = epsm_pkg::OP_NUM_DBL;
            state_in = S_INV;
         end
         S_NUMADD: begin
            cmd.op   = epsm_pkg::OP_NUM_ADD;
            state_in = S_INV;
         end
         S_INV: begin
            cmd.op = epsm_pkg::OP_INV;
            if (status.done) state_in = status.inv_ok ? S_LAM : S_WR_INF;
         end
         S_LAM: begin
            cmd.op = epsm_pkg::OP_MUL_NI;
            if (status.done) state_in = S_LL;
         end
         S_LL: begin
            cmd.op = epsm_pkg::OP_MUL_LL;
            if (status.done) state_in = S_X3;
         end
         S_X3: begin
            cmd.op   = epsm_pkg::OP_X3;
            state_in = S_SUBX;
         end
         S_SUBX: begin
            cmd.op   = epsm_pkg::OP_SUB_X;
            state_in = S_MLT;
         end
         S_MLT: begin
            cmd.op = epsm_pkg::OP_MUL_LT;
            if (status.done) state_in = S_Y3;
         end
         S_Y3: begin
            cmd.op   = epsm_pkg::OP_Y3;
            state_in = S_WR_NEW;
         end
         S_WR_P, S_WR_Q, S_WR_INF, S_WR_NEW: begin
            if (state_ff == S_WR_P)        cmd.op = epsm_pkg::OP_WR_P;
            else if (state_ff == S_WR_Q)   cmd.op = epsm_pkg::OP_WR_Q;
            else if (state_ff == S_WR_INF) cmd.op = epsm_pkg::OP_WR_INF;
            else                           cmd.op = epsm_pkg::OP_WR_NEW;
            // After the accumulator update the same bit still doubles the power.
            if (!sel_ff) begin
               sel_in   = 1'b1;
               state_in = S_PQ;
            end else begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            cmd.op   = epsm_pkg::OP_SHIFT_K;
            state_in = S_LOOP;
         end
         S_FIN: begin
            if (!status.out_busy) begin
               cmd.op   = epsm_pkg::OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ----- hdl/epsm_datapath.sv -----
// Datapath of the point multiplier: configuration registers, point registers,
// a bit-serial modular multiplier and reducer, an inverse search and the
// result register. Depends on epsm_pkg.
module epsm_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  epsm_pkg::csr_idx_type csr_index,
   input  epsm_pkg::field_type   csr_wr_data,
   input  epsm_pkg::field_type   in_x,
   input  epsm_pkg::field_type   in_y,
   input  logic                  in_inf,
   input  epsm_pkg::scalar_type  in_k,
   input  epsm_pkg::cmd_type     cmd,
   output epsm_pkg::status_type  status,
   output logic                  out_valid,
   input  logic                  out_ready,
   output epsm_pkg::field_type   out_x,
   output epsm_pkg::field_type   out_y,
   output logic                  out_inf
);

   typedef epsm_pkg::field_type fld_type;

   fld_type mod_ff, mod_in, cfga_ff, cfga_in;
   fld_type m_ff, m_in, rawa_ff, rawa_in, rawx_ff, rawx_in, rawy_ff, rawy_in;
   fld_type ca_ff, ca_in;
   epsm_pkg::scalar_type k_ff, k_in;
   logic    skip_ff, skip_in;
   fld_type px_ff, px_in, py_ff, py_in;
   logic    pinf_ff, pinf_in;
   fld_type ax_ff, ax_in, ay_ff, ay_in;
   logic    ainf_ff, ainf_in;
   fld_type x1_ff, x1_in, y1_ff, y1_in, x2_ff, x2_in, y2_ff, y2_in;
   logic    i1_ff, i1_in, i2_ff, i2_in;
   fld_type num_ff, num_in, den_ff, den_in, inv_ff, inv_in, lam_ff, lam_in;
   fld_type tmp_ff, tmp_in, x3_ff, x3_in, y3_ff, y3_in;
   fld_type mu_ff, mu_in, mv_ff, mv_in, macc_ff, macc_in;
   epsm_pkg::cnt_type cnt_ff, cnt_in;
   fld_type rx_ff, rx_in, ry_ff, ry_in;
   logic    rinf_ff, rinf_in, rvalid_ff, rvalid_in;

   logic    is_mul, is_red, is_inv, loop_end, inv_stop;
   fld_type op_a, op_b, src, step_acc, red_acc, unit_res, wx, wy;
   logic [epsm_pkg::FIELD_BITS:0] red_sh;
   logic    wi;

   always_comb begin
      is_mul = (cmd.op == epsm_pkg::OP_MUL_XX) || (cmd.op == epsm_pkg::OP_MUL_NI) ||
               (cmd.op == epsm_pkg::OP_MUL_LL) || (cmd.op == epsm_pkg::OP_MUL_LT);
      is_red = (cmd.op == epsm_pkg::OP_RED_X) || (cmd.op == epsm_pkg::OP_RED_Y) ||
               (cmd.op == epsm_pkg::OP_RED_A);
      is_inv = (cmd.op == epsm_pkg::OP_INV);
      loop_end = (cnt_ff == epsm_pkg::cnt_type'(epsm_pkg::FIELD_BITS));
      inv_stop = (cnt_ff != '0) &&
                 ((macc_ff == fld_type'(1)) || (mu_ff == fld_type'(m_ff - 1'b1)));

      unique case (cmd.op)
         epsm_pkg::OP_MUL_XX: begin op_a = x1_ff;  op_b = x1_ff;  end
         epsm_pkg::OP_MUL_NI: begin op_a = num_ff; op_b = inv_ff; end
         epsm_pkg::OP_MUL_LL: begin op_a = lam_ff; op_b = lam_ff; end
         default:             begin op_a = lam_ff; op_b = tmp_ff; end
      endcase
      unique case (cmd.op)
         epsm_pkg::OP_RED_X: src = rawx_ff;
         epsm_pkg::OP_RED_Y: src = rawy_ff;
         default:            src = rawa_ff;
      endcase

      // One step of shift-and-add multiplication, least significant bit first.
      step_acc = mv_ff[0] ? epsm_pkg::fadd(macc_ff, mu_ff, m_ff) : macc_ff;
      // One step of restoring remainder, most significant bit first.
      red_sh  = {macc_ff, mv_ff[epsm_pkg::FIELD_BITS-1]};
      if (red_sh >= {1'b0, m_ff}) red_sh = red_sh - {1'b0, m_ff};
      red_acc = red_sh[epsm_pkg::FIELD_BITS-1:0];
      unit_res = is_mul ? step_acc : red_acc;

      status.done     = (is_mul || is_red) ? loop_end : (is_inv ? inv_stop : 1'b1);
      status.p_inf    = i1_ff;
      status.q_inf    = i2_ff;
      status.opp      = (x1_ff == x2_ff) && (epsm_pkg::fadd(y1_ff, y2_ff, m_ff) == '0);
      status.dbl      = (x1_ff == x2_ff) && (y1_ff == y2_ff);
      status.inv_ok   = (macc_ff == fld_type'(1));
      status.k_zero   = (k_ff == '0);
      status.k_lsb    = k_ff[0];
      status.skip     = skip_ff;
      status.out_busy = rvalid_ff;
   end

   always_comb begin
      mod_in = mod_ff; cfga_in = cfga_ff;
      m_in = m_ff; rawa_in = rawa_ff; rawx_in = rawx_ff; rawy_in = rawy_ff;
      ca_in = ca_ff; k_in = k_ff; skip_in = skip_ff;
      px_in = px_ff; py_in = py_ff; pinf_in = pinf_ff;
      ax_in = ax_ff; ay_in = ay_ff; ainf_in = ainf_ff;
      x1_in = x1_ff; y1_in = y1_ff; x2_in = x2_ff; y2_in = y2_ff;
      i1_in = i1_ff; i2_in = i2_ff;
      num_in = num_ff; den_in = den_ff; inv_in = inv_ff; lam_in = lam_ff;
      tmp_in = tmp_ff; x3_in = x3_ff; y3_in = y3_ff;
      mu_in = mu_ff; mv_in = mv_ff; macc_in = macc_ff; cnt_in = cnt_ff;
      rx_in = rx_ff; ry_in = ry_ff; rinf_in = rinf_ff;
      rvalid_in = (rvalid_ff && out_ready) ? 1'b0 : rvalid_ff;
      wx = '0; wy = '0; wi = 1'b1;

      if (csr_wr_en) begin
         if (csr_index == epsm_pkg::REG_MODULUS) mod_in  = csr_wr_data;
         if (csr_index == epsm_pkg::REG_CURVE_A) cfga_in = csr_wr_data;
      end

      // Multi-cycle units: count zero loads the operands, later counts step.
      if (is_mul || is_red) begin
         if (cnt_ff == '0) begin
            mu_in   = op_a;
            mv_in   = is_mul ? op_b : src;
            macc_in = '0;
            cnt_in  = epsm_pkg::cnt_type'(1);
         end else begin
            mu_in   = epsm_pkg::fadd(mu_ff, mu_ff, m_ff);
            mv_in   = is_mul ? (mv_ff >> 1) : (mv_ff << 1);
            macc_in = unit_res;
            cnt_in  = loop_end ? '0 : cnt_ff + 1'b1;
         end
      end else if (is_inv) begin
         // Linear search: macc holds mu * den as mu counts up.
         if (cnt_ff == '0) begin
            mu_in   = fld_type'(1);
            macc_in = den_ff;
            cnt_in  = epsm_pkg::cnt_type'(1);
         end else if (inv_stop) begin
            inv_in = mu_ff;
            cnt_in = '0;
         end else begin
            mu_in   = mu_ff + 1'b1;
            macc_in = epsm_pkg::fadd(macc_ff, den_ff, m_ff);
         end
      end

      unique case (cmd.op)
         epsm_pkg::OP_CAPTURE: begin
            m_in = mod_ff; rawa_in = cfga_ff;
            rawx_in = in_x; rawy_in = in_y; k_in = in_k;
            skip_in = in_inf || (mod_ff < fld_type'(2));
            ax_in = '0; ay_in = '0; ainf_in = 1'b1;
         end
         epsm_pkg::OP_RED_X: if (loop_end) begin px_in = unit_res; pinf_in = 1'b0; end
         epsm_pkg::OP_RED_Y: if (loop_end) py_in = unit_res;
         epsm_pkg::OP_RED_A: if (loop_end) ca_in = unit_res;
         epsm_pkg::OP_LOAD_PQ: begin
            x1_in = cmd.sel_dbl ? px_ff : ax_ff;
            y1_in = cmd.sel_dbl ? py_ff : ay_ff;
            i1_in = cmd.sel_dbl ? pinf_ff : ainf_ff;
            x2_in = px_ff; y2_in = py_ff; i2_in = pinf_ff;
         end
         epsm_pkg::OP_MUL_XX, epsm_pkg::OP_MUL_LL, epsm_pkg::OP_MUL_LT:
            if (loop_end) tmp_in = unit_res;
         epsm_pkg::OP_MUL_NI: if (loop_end) lam_in = unit_res;
         epsm_pkg::OP_NUM_DBL: begin
            num_in = epsm_pkg::fadd(epsm_pkg::fadd(epsm_pkg::fadd(tmp_ff, tmp_ff, m_ff),
                                                   tmp_ff, m_ff), ca_ff, m_ff);
            den_in = epsm_pkg::fadd(y1_ff, y1_ff, m_ff);
         end
         epsm_pkg::OP_NUM_ADD: begin
            num_in = epsm_pkg::fsub(y2_ff, y1_ff, m_ff);
            den_in = epsm_pkg::fsub(x2_ff, x1_ff, m_ff);
         end
         epsm_pkg::OP_X3:
            x3_in = epsm_pkg::fsub(epsm_pkg::fsub(tmp_ff, x1_ff, m_ff), x2_ff, m_ff);
         epsm_pkg::OP_SUB_X: tmp_in = epsm_pkg::fsub(x1_ff, x3_ff, m_ff);
         epsm_pkg::OP_Y3:    y3_in  = epsm_pkg::fsub(tmp_ff, y1_ff, m_ff);
         epsm_pkg::OP_WR_P, epsm_pkg::OP_WR_Q, epsm_pkg::OP_WR_INF,
         epsm_pkg::OP_WR_NEW: begin
            if (cmd.op == epsm_pkg::OP_WR_P) begin
               wx = x1_ff; wy = y1_ff; wi = i1_ff;
            end else if (cmd.op == epsm_pkg::OP_WR_Q) begin
               wx = x2_ff; wy = y2_ff; wi = i2_ff;
            end else if (cmd.op == epsm_pkg::OP_WR_NEW) begin
               wx = x3_ff; wy = y3_ff; wi = 1'b0;
            end
            if (cmd.sel_dbl) begin
               px_in = wx; py_in = wy; pinf_in = wi;
            end else begin
               ax_in = wx; ay_in = wy; ainf_in = wi;
            end
         end
         epsm_pkg::OP_SHIFT_K: k_in = k_ff >> 1;
         epsm_pkg::OP_OUT: begin
            rx_in     = ainf_ff ? '0 : ax_ff;
            ry_in     = ainf_ff ? '0 : ay_ff;
            rinf_in   = ainf_ff;
            rvalid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff    <= epsm_pkg::MODULUS_RESET;
         cfga_ff   <= epsm_pkg::CURVE_A_RESET;
         cnt_ff    <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         mod_ff    <= mod_in;
         cfga_ff   <= cfga_in;
         cnt_ff    <= cnt_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in; rawa_ff <= rawa_in; rawx_ff <= rawx_in; rawy_ff <= rawy_in;
      ca_ff <= ca_in; k_ff <= k_in; skip_ff <= skip_in;
      px_ff <= px_in; py_ff <= py_in; pinf_ff <= pinf_in;
      ax_ff <= ax_in; ay_ff <= ay_in; ainf_ff <= ainf_in;
      x1_ff <= x1_in; y1_ff <= y1_in; x2_ff <= x2_in; y2_ff <= y2_in;
      i1_ff <= i1_in; i2_ff <= i2_in;
      num_ff <= num_in; den_ff <= den_in; inv_ff <= inv_in; lam_ff <= lam_in;
      tmp_ff <= tmp_in; x3_ff <= x3_in; y3_ff <= y3_in;
      mu_ff <= mu_in; mv_ff <= mv_in; macc_ff <= macc_in;
      rx_ff <= rx_in; ry_ff <= ry_in; rinf_ff <= rinf_in;
   end

   assign out_valid = rvalid_ff;
   assign out_x     = rx_ff;
   assign out_y     = ry_ff;
   assign out_inf   = rinf_ff;

endmodule

// ----- hdl/ecc_point_scalar_multiply_core.sv -----
// Elliptic-curve point scalar multiplier, right-to-left double-and-add.
// One item at a time: after setup, each point addition or doubling uses the
// 8-step serial multiplier and a linear inverse search over the field; these
// two units set how long an item takes.
// Synchronous active-high reset; modulus resets to 97 and curve_a to 2.
module ecc_point_scalar_multiply_core (
   input  logic                  clock,
   input  logic                  reset,
   epsm_req_if.sink              req_chan,
   epsm_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  epsm_pkg::csr_idx_type csr_index,
   input  epsm_pkg::field_type   csr_wr_data
);

   epsm_pkg::cmd_type    cmd;
   epsm_pkg::status_type status;

   epsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   epsm_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .in_x        (req_chan.base_x),
      .in_y        (req_chan.base_y),
      .in_inf      (req_chan.base_infinity),
      .in_k        (req_chan.scalar),
      .cmd         (cmd),
      .status      (status),
      .out_valid   (rsp_chan.valid),
      .out_ready   (rsp_chan.ready),
      .out_x       (rsp_chan.result_x),
      .out_y       (rsp_chan.result_y),
      .out_inf     (rsp_chan.result_infinity)
   );

endmodule

// ----- hdl/epsm_checker.sv -----
// Port-level checks of the point multiplier, bound to the top level.
// Depends on epsm_pkg and ecc_point_scalar_multiply_core.
module epsm_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input epsm_pkg::field_type rsp_x,
   input epsm_pkg::field_type rsp_y,
   input logic                rsp_inf
);

   // A pending result is held until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before it was taken");

   // The block works on one item at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new item taken while one is in progress");

   // The point at infinity is always reported with zero coordinates.
   a_inf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inf |-> rsp_x == '0 && rsp_y == '0)
      else $error("infinity reported with nonzero coordinates");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind ecc_point_scalar_multiply_core epsm_checker u_epsm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_x     (rsp_chan.result_x),
   .rsp_y     (rsp_chan.result_y),
   .rsp_inf   (rsp_chan.result_infinity)
);
